/* hdl/jpdtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdtc_pkg: shared types and constants of the joint PD torque controller
// Holds field widths, the controller state enum and the command/status structs.
// ----------------------------------------------------------------------------
package jpdtc_pkg;

    localparam int MAX_JOINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int JW         = $clog2(MAX_JOINTS);
    localparam int DW         = 32;
    localparam logic [15:0] TPS_RESET = 16'd1000;

    // gain term selectors
    localparam logic [1:0] TERM_P  = 2'd0;
    localparam logic [1:0] TERM_D  = 2'd1;
    localparam logic [1:0] TERM_TP = 2'd2;
    localparam logic [1:0] TERM_TD = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV_A,
        ST_DIV_T,
        ST_RATE,
        ST_TERM_P,
        ST_TERM_D,
        ST_TERM_TP,
        ST_TERM_TD,
        ST_SUM,
        ST_DIV_N,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_state;
        logic load;
        logic div_a;
        logic div_t;
        logic div_n;
        logic rate;
        logic [1:0] term_sel;
        logic term;
        logic sum;
        logic clamp;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic ptmode;
        logic out_range;
    } t_status;

endpackage

/* hdl/jpdtc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdtc_ctrl: sequencer of the controller
// Steps one tick through reading state, divisions, gain terms and clamp.
// ----------------------------------------------------------------------------
module jpdtc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_beat,
    input  logic               i_out_taken,
    input  jpdtc_pkg::t_status i_status,
    output jpdtc_pkg::t_cmd    o_cmd,
    output logic               o_idle,
    output logic               o_out_valid
);

    jpdtc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jpdtc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jpdtc_pkg::ST_IDLE:    if (i_in_beat) n_state = jpdtc_pkg::ST_READ;
            jpdtc_pkg::ST_READ:    n_state = i_status.out_range ? jpdtc_pkg::ST_OUT
                                                                : jpdtc_pkg::ST_LOAD;
            jpdtc_pkg::ST_LOAD:    n_state = jpdtc_pkg::ST_DIV_A;
            jpdtc_pkg::ST_DIV_A:   if (!i_status.div_busy) n_state = jpdtc_pkg::ST_DIV_T;
            jpdtc_pkg::ST_DIV_T:   if (!i_status.div_busy) n_state = jpdtc_pkg::ST_RATE;
            jpdtc_pkg::ST_RATE:    n_state = jpdtc_pkg::ST_TERM_P;
            jpdtc_pkg::ST_TERM_P:  n_state = jpdtc_pkg::ST_TERM_D;
            jpdtc_pkg::ST_TERM_D:  n_state = i_status.ptmode ? jpdtc_pkg::ST_TERM_TP
                                                             : jpdtc_pkg::ST_SUM;
            jpdtc_pkg::ST_TERM_TP: n_state = jpdtc_pkg::ST_TERM_TD;
            jpdtc_pkg::ST_TERM_TD: n_state = jpdtc_pkg::ST_SUM;
            jpdtc_pkg::ST_SUM:     n_state = i_status.ptmode ? jpdtc_pkg::ST_DIV_N
                                                             : jpdtc_pkg::ST_CLAMP;
            jpdtc_pkg::ST_DIV_N:   if (!i_status.div_busy) n_state = jpdtc_pkg::ST_CLAMP;
            jpdtc_pkg::ST_CLAMP:   n_state = jpdtc_pkg::ST_OUT;
            jpdtc_pkg::ST_OUT:     if (i_out_taken) n_state = jpdtc_pkg::ST_IDLE;
            default:               n_state = jpdtc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_idle      = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            jpdtc_pkg::ST_IDLE:    begin
                o_idle = 1'b1;
                o_cmd.start = i_in_beat;
            end
            jpdtc_pkg::ST_READ:    o_cmd.rd_state = 1'b1;
            jpdtc_pkg::ST_LOAD:    o_cmd.load = 1'b1;
            jpdtc_pkg::ST_DIV_A:   o_cmd.div_a = 1'b1;
            jpdtc_pkg::ST_DIV_T:   o_cmd.div_t = 1'b1;
            jpdtc_pkg::ST_RATE:    o_cmd.rate = 1'b1;
            jpdtc_pkg::ST_TERM_P:  begin
                o_cmd.term = 1'b1;
                o_cmd.term_sel = jpdtc_pkg::TERM_P;
            end
            jpdtc_pkg::ST_TERM_D:  begin
                o_cmd.term = 1'b1;
                o_cmd.term_sel = jpdtc_pkg::TERM_D;
            end
            jpdtc_pkg::ST_TERM_TP: begin
                o_cmd.term = 1'b1;
                o_cmd.term_sel = jpdtc_pkg::TERM_TP;
            end
            jpdtc_pkg::ST_TERM_TD: begin
                o_cmd.term = 1'b1;
                o_cmd.term_sel = jpdtc_pkg::TERM_TD;
            end
            jpdtc_pkg::ST_SUM:     o_cmd.sum = 1'b1;
            jpdtc_pkg::ST_DIV_N:   o_cmd.div_n = 1'b1;
            jpdtc_pkg::ST_CLAMP:   o_cmd.clamp = 1'b1;
            jpdtc_pkg::ST_OUT:     begin
                o_out_valid = 1'b1;
                o_cmd.emit = i_out_taken;
            end
            default:               o_cmd = '0;
        endcase
    end

endmodule

/* hdl/jpdtc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdtc_div: shared signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module jpdtc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic        [32:0] i_den,
    output logic               o_busy,
    output logic signed [63:0] o_quot
);

    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic [63:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [33:0] w_trial;
    logic [33:0] w_sub;

    assign w_trial = {r_rem[32:0], r_q[63]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) r_busy <= 1'b0;
        end
    end

    // shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_neg <= i_num[63];
            r_q   <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[33]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy || i_start;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

/* hdl/jpdtc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdtc_dp: datapath of the controller
// Joint state memory, operand registers, shared gain-term multiplier, rate multipliers and shared divider.
// ----------------------------------------------------------------------------
module jpdtc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jpdtc_pkg::t_cmd    i_cmd,
    input  logic [15:0]        i_tps,
    input  logic [7:0]         i_joint,
    input  logic signed [31:0] i_q,
    input  logic signed [31:0] i_tq,
    input  logic signed [31:0] i_q_tgt,
    input  logic signed [31:0] i_tq_tgt,
    input  logic [7:0]         i_steps,
    input  logic               i_ptmode,
    input  logic [31:0]        i_kp,
    input  logic [31:0]        i_kd,
    input  logic [31:0]        i_ktp,
    input  logic [31:0]        i_ktd,
    input  logic [30:0]        i_lim,
    output jpdtc_pkg::t_status o_status,
    output logic [5:0]         o_joint,
    output logic signed [31:0] o_torque,
    output logic               o_sat
);

    localparam int SW = 4 * jpdtc_pkg::DW;

    // joint state memory {prev_ref_torque, prev_torque, prev_ref_angle, prev_angle}
    logic [SW-1:0] r_mem [jpdtc_pkg::MAX_JOINTS];
    logic [SW-1:0] r_rd;
    logic [jpdtc_pkg::MAX_JOINTS-1:0] r_seeded;

    // captured item
    logic [7:0]         r_joint;
    logic signed [31:0] r_q, r_tq, r_q_tgt, r_tq_tgt;
    logic [7:0]         r_steps;
    logic               r_ptmode;
    logic [31:0]        r_kp, r_kd, r_ktp, r_ktd;
    logic [30:0]        r_lim;
    logic [15:0]        r_tps;

    // working registers
    logic signed [31:0] r_qo, r_qro, r_tqo, r_tqro, r_qref, r_tqref;
    logic signed [63:0] r_dq_err, r_dtq_err;
    logic signed [63:0] r_acc;
    logic               r_sat;
    logic               r_first;
    logic signed [31:0] r_torque;

    logic [jpdtc_pkg::JW-1:0] w_idx;
    logic                     w_out_range;
    assign w_idx       = r_joint[jpdtc_pkg::JW-1:0];
    assign w_out_range = (r_joint >= 8'(jpdtc_pkg::MAX_JOINTS));

    // divider shared by both references and the torque law
    logic               w_div_start;
    logic signed [63:0] w_num;
    logic [32:0]        w_den;
    logic               w_div_busy;
    logic signed [63:0] w_quot;
    logic               r_div_go;

    always_comb begin
        w_num = 64'(r_q_tgt) - 64'(r_qro);
        w_den = 33'(r_steps);
        if (i_cmd.div_t) w_num = 64'(r_tq_tgt) - 64'(r_tqro);
        if (i_cmd.div_n) begin
            w_num = r_acc <<< jpdtc_pkg::FRAC_BITS;
            w_den = 33'(r_ktp) + (33'd1 << jpdtc_pkg::FRAC_BITS);
        end
    end
    assign w_div_start = r_div_go && (i_cmd.div_a || i_cmd.div_t || i_cmd.div_n)
                         && !(i_cmd.div_a && r_steps == 8'd0)
                         && !(i_cmd.div_t && r_steps == 8'd0);

    jpdtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // saturate helpers
    function automatic logic signed [31:0] f_sat(input logic signed [65:0] x,
                                                output logic flag);
        flag = 1'b0;
        if (x > 66'sd2147483647) begin
            flag = 1'b1;
            f_sat = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            flag = 1'b1;
            f_sat = 32'sh80000000;
        end else begin
            f_sat = x[31:0];
        end
    endfunction

    // gain term: sat32(err) * gain, floor shift, sat32
    logic signed [63:0] w_err;
    logic [31:0]        w_gain;
    logic signed [31:0] w_e32;
    logic               w_f1, w_f2;
    logic signed [64:0] w_prod;
    logic signed [31:0] w_term;

    always_comb begin
        case (i_cmd.term_sel)
            jpdtc_pkg::TERM_P:  begin w_err = 64'(r_q) - 64'(r_qref); w_gain = r_kp;  end
            jpdtc_pkg::TERM_D:  begin w_err = r_dq_err;               w_gain = r_kd;  end
            jpdtc_pkg::TERM_TP: begin w_err = 64'(r_tqref);           w_gain = r_ktp; end
            default:            begin w_err = r_dtq_err;              w_gain = r_ktd; end
        endcase
        w_e32  = f_sat(66'(w_err), w_f1);
        w_prod = 65'(w_e32) * $signed({33'd0, w_gain});
        w_term = f_sat(66'(w_prod >>> jpdtc_pkg::FRAC_BITS), w_f2);
    end

    // rate products
    logic signed [63:0] w_dq_err, w_dtq_err;
    assign w_dq_err  = ((64'(r_q) - 64'(r_qo)) - (64'(r_qref) - 64'(r_qro)))
                       * $signed({48'd0, r_tps});
    assign w_dtq_err = ((64'(r_tq) - 64'(r_tqo)) - (64'(r_tqref) - 64'(r_tqro)))
                       * $signed({48'd0, r_tps});

    // clamp
    logic signed [63:0] w_lim;
    assign w_lim = 64'(r_lim);

    // pulse the divider go flag on the first cycle of each division state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= i_cmd.load || (i_cmd.div_a && !w_div_busy && !r_div_go)
                        || i_cmd.sum;
            if (i_cmd.rd_state && !w_out_range) r_seeded[w_idx] <= 1'b1;
        end
    end

    // state memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_state && !w_out_range) r_rd <= r_mem[w_idx];
        if (i_cmd.clamp && !w_out_range)
            r_mem[w_idx] <= {r_tqref, r_tq, r_qref, r_q};
    end

    // capture, sequence the arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_joint  <= i_joint;
            r_q      <= i_q;
            r_tq     <= i_tq;
            r_q_tgt  <= i_q_tgt;
            r_tq_tgt <= i_tq_tgt;
            r_steps  <= i_steps;
            r_ptmode <= i_ptmode;
            r_kp     <= i_kp;
            r_kd     <= i_kd;
            r_ktp    <= i_ktp;
            r_ktd    <= i_ktd;
            r_lim    <= i_lim;
            r_tps    <= i_tps;
            r_sat    <= 1'b0;
            r_acc    <= '0;
            r_torque <= '0;
        end
        if (i_cmd.rd_state) r_first <= !w_out_range && !r_seeded[w_idx];
        if (i_cmd.load) begin
            if (r_first) begin
                r_qo <= r_q; r_qro <= r_q; r_tqo <= '0; r_tqro <= '0;
            end else begin
                r_qo   <= r_rd[31:0];
                r_qro  <= r_rd[63:32];
                r_tqo  <= r_rd[95:64];
                r_tqro <= r_rd[127:96];
            end
        end
        if (i_cmd.div_a && !w_div_busy)
            r_qref <= (r_steps == 8'd0) ? r_qro : 32'(64'(r_qro) + w_quot);
        if (i_cmd.div_t && !w_div_busy)
            r_tqref <= (r_steps == 8'd0) ? r_tqro : 32'(64'(r_tqro) + w_quot);
        if (i_cmd.rate) begin
            r_dq_err  <= w_dq_err;
            r_dtq_err <= w_dtq_err;
        end
        // accumulate terms: TP adds, the rest subtract
        if (i_cmd.term) begin
            r_sat <= r_sat | w_f1 | w_f2;
            if (i_cmd.term_sel == jpdtc_pkg::TERM_TP) r_acc <= r_acc + 64'(w_term);
            else                                      r_acc <= r_acc - 64'(w_term);
        end
        if (i_cmd.div_n && !w_div_busy) r_acc <= w_quot;
        if (i_cmd.clamp) begin
            if (r_acc > w_lim) begin
                r_torque <= 32'(w_lim); r_sat <= 1'b1;
            end else if (r_acc < -w_lim) begin
                r_torque <= 32'(-w_lim); r_sat <= 1'b1;
            end else begin
                r_torque <= 32'(r_acc);
            end
        end
    end

    assign o_status.div_busy  = w_div_busy || r_div_go;
    assign o_status.ptmode    = r_ptmode;
    assign o_status.out_range = w_out_range;
    assign o_joint            = r_joint[5:0];
    assign o_torque           = r_torque;
    assign o_sat              = r_sat;

endmodule

/* hdl/joint_pd_torque_controller_core.sv */
`timescale 1ns / 1ps
// In position-torque mode each tick runs three divisions, in plain PD mode two; each
// holds the shared one-bit-per-cycle divider until it is done, and zero steps_left
// lets the two reference divisions skip the divider.
// Throughput: one tick in flight; the next beat is taken in the cycle after the
// result beat at the earliest.
// Reset (synchronous, active low) clears all seeded flags and sets the rate to 1000.
// ----------------------------------------------------------------------------
// joint_pd_torque_controller_core: per-joint PD torque controller
// Reference interpolation, PD or position-torque law, output clamp.
// ----------------------------------------------------------------------------
module joint_pd_torque_controller_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint_index[5:0], measured_angle[37:6], measured_torque[69:38],
    // target_angle[101:70], target_torque[133:102], steps_left[141:134],
    // pos_torque_mode[142], p_gain[174:143], d_gain[206:175],
    // torque_p_gain[238:207], torque_d_gain[270:239], torque_limit[301:271]
    input  logic [303:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_joint[5:0], drive_torque[37:6], saturated[38]
    output logic [39:0]  m_axis_tdata
);

    logic [15:0]        r_tps;
    jpdtc_pkg::t_cmd    w_cmd;
    jpdtc_pkg::t_status w_status;
    logic               w_idle;
    logic [5:0]         w_joint;
    logic signed [31:0] w_torque;
    logic               w_sat;

    // hold the rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= jpdtc_pkg::TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = w_idle;

    jpdtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (s_axis_tvalid),
        .i_out_taken (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_out_valid (m_axis_tvalid)
    );

    jpdtc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_tps    (r_tps),
        .i_joint  ({2'b00, s_axis_tdata[5:0]}),
        .i_q      (s_axis_tdata[37:6]),
        .i_tq     (s_axis_tdata[69:38]),
        .i_q_tgt  (s_axis_tdata[101:70]),
        .i_tq_tgt (s_axis_tdata[133:102]),
        .i_steps  (s_axis_tdata[141:134]),
        .i_ptmode (s_axis_tdata[142]),
        .i_kp     (s_axis_tdata[174:143]),
        .i_kd     (s_axis_tdata[206:175]),
        .i_ktp    (s_axis_tdata[238:207]),
        .i_ktd    (s_axis_tdata[270:239]),
        .i_lim    (s_axis_tdata[301:271]),
        .o_status (w_status),
        .o_joint  (w_joint),
        .o_torque (w_torque),
        .o_sat    (w_sat)
    );

    assign m_axis_tdata = {1'b0, w_sat, w_torque, w_joint};

endmodule

/* hdl/jpdtc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpdtc_checker: port-level checks of the controller
// Watches the stream ports for ordering of beats and the result pad bit.
// ----------------------------------------------------------------------------
module jpdtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // drop a result only after it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before taken");

    // never accept while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // no result right after an input beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");

    // pad bit stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[39])
        else $error("pad bit set");

endmodule

bind joint_pd_torque_controller_core jpdtc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: joint PD torque controller regression
// Drives joint ticks and rate settings, predicts each torque command from a
// behavioral copy of the per-joint state, and checks every result beat.
// ----------------------------------------------------------------------------

class torque_scoreboard;
    // predicted beats: {saturated, drive_torque, out_joint}
    logic [38:0] pending_q[$];
    logic [15:0] tps;
    logic signed [31:0] last_angle[64];
    logic signed [31:0] last_ref_angle[64];
    logic signed [31:0] last_torque[64];
    logic signed [31:0] last_ref_torque[64];
    bit seeded[64];
    int errors;

    function void clear();
        tps = jpdtc_pkg::TPS_RESET;
        for (int i = 0; i < 64; i++) seeded[i] = 0;
        pending_q.delete();
        errors = 0;
    endfunction

    function longint sat32(longint x, ref bit flag);
        if (x > 64'sd2147483647) begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            flag = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // saturate error, multiply by unsigned gain, floor shift, saturate
    function longint scaled_term(longint err, logic [31:0] gain, ref bit flag);
        longint a;
        logic [63:0] mag;
        logic [63:0] prod;
        longint r;
        a = sat32(err, flag);
        mag = (a < 0) ? -a : a;
        prod = mag * {32'd0, gain};
        if (a >= 0) r = longint'(prod >> jpdtc_pkg::FRAC_BITS);
        else r = -longint'((prod + 64'hFFFF) >> jpdtc_pkg::FRAC_BITS);
        return sat32(r, flag);
    endfunction

    // note an accepted tick and queue its torque command
    function void note_tick(logic [303:0] d);
        logic [5:0] j;
        longint q, tq, qt, tqt, steps, lim, t, qo, qro, tqo, tqro, qr, tqr;
        longint dq, dtq, tp_, td_, num, den, cmd;
        bit ptm, flag;
        j = d[5:0];
        q = longint'($signed(d[37:6]));
        tq = longint'($signed(d[69:38]));
        qt = longint'($signed(d[101:70]));
        tqt = longint'($signed(d[133:102]));
        steps = longint'(d[141:134]);
        ptm = d[142];
        lim = longint'(d[301:271]);
        t = longint'(tps);
        flag = 0;
        if (!seeded[j]) begin
            last_angle[j] = q;
            last_ref_angle[j] = q;
            last_torque[j] = 0;
            last_ref_torque[j] = 0;
            seeded[j] = 1;
        end
        qo = last_angle[j];
        qro = last_ref_angle[j];
        tqo = last_torque[j];
        tqro = last_ref_torque[j];
        qr = (steps == 0) ? qro : qro + (qt - qro) / steps;
        tqr = (steps == 0) ? tqro : tqro + (tqt - tqro) / steps;
        dq = (q - qo) * t - (qr - qro) * t;
        dtq = (tq - tqo) * t - (tqr - tqro) * t;
        tp_ = scaled_term(q - qr, d[174:143], flag);
        td_ = scaled_term(dq, d[206:175], flag);
        if (ptm) begin
            num = -tp_ - td_ + scaled_term(tqr, d[238:207], flag)
                  - scaled_term(dtq, d[270:239], flag);
            den = longint'(d[238:207]) + 65536;
            cmd = (num * 65536) / den;
        end else begin
            cmd = -tp_ - td_;
        end
        if (cmd > lim) begin
            cmd = lim;
            flag = 1;
        end
        if (cmd < -lim) begin
            cmd = -lim;
            flag = 1;
        end
        last_angle[j] = q;
        last_ref_angle[j] = qr;
        last_torque[j] = tq;
        last_ref_torque[j] = tqr;
        pending_q.push_back({flag, cmd[31:0], j});
    endfunction

    task report(string what, logic [38:0] got, logic [38:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [39:0] d);
        logic [38:0] w;
        if (pending_q.size() == 0) begin
            report("unexpected beat", d[38:0], 39'd0);
            return;
        end
        w = pending_q.pop_front();
        if (d[5:0] != w[5:0]) report("out_joint", d[38:0], w);
        if (d[37:6] != w[37:6]) report("drive_torque", d[38:0], w);
        if (d[38] != w[38]) report("saturated", d[38:0], w);
    endtask
endclass

module testbench;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [15:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [303:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [39:0] m_axis_tdata;

    torque_scoreboard board;
    int idle_cycles;
    int ticks_sent;
    bit calm;
    bit timed_out;

    joint_pd_torque_controller_core uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // sample beats at the rising edge; watchdog on no progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) board.note_tick(s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) timed_out = 1;
        end
    end

    // receiver backpressure in bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 6);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    // hold valid across back-to-back ticks; drop it only for an idle burst
    task automatic send_tick(logic [303:0] d);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            s_axis_tvalid <= 0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending_q.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] v);
        drain();
        i_cfg_wdata <= v;
        i_cfg_we <= 1;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.tps = v;
    endtask

    function automatic logic [31:0] rnd_word(int style);
        case (style)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default: return $urandom_range(0, 32'h0000_4000);
        endcase
    endfunction

    // build one tick: joint, angles, torques, steps, mode, gains, limit
    function automatic logic [303:0] make_tick(logic [5:0] j, int style);
        logic [303:0] d;
        d = '0;
        d[5:0] = j;
        d[37:6] = rnd_word(style == 0 ? 0 : 1);
        d[69:38] = rnd_word(style == 0 ? 0 : 1);
        d[101:70] = rnd_word(style == 0 ? 0 : 1);
        d[133:102] = rnd_word(style == 0 ? 0 : 1);
        d[141:134] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom());
        d[142] = 1'($urandom_range(0, 1));
        d[174:143] = rnd_word(style == 0 ? 0 : 2) << (style == 0 ? 0 : 4);
        d[206:175] = rnd_word(style == 0 ? 0 : 2);
        d[238:207] = rnd_word(style == 0 ? 0 : 2) << (style == 0 ? 0 : 4);
        d[270:239] = rnd_word(style == 0 ? 0 : 2);
        d[301:271] = (style == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h0100_0000));
        if ($urandom_range(0, 15) == 0) d[301:271] = '0;
        return d;
    endfunction

    initial begin
        logic [303:0] d;
        logic [15:0] rates[4];
        board = new();
        board.clear();
        idle_cycles = 0;
        ticks_sent = 0;
        calm = 0;
        timed_out = 0;
        rates = '{16'd1, 16'd65535, 16'd0, 16'd250};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: field extremes, both modes, zero steps, zero limit
        d = '0;
        send_tick(d);
        d = {2'b0, 31'h7FFF_FFFF, {4{32'hFFFF_FFFF}}, 1'b1, 8'hFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 6'd63};
        send_tick(d);
        d[37:6] = 32'h8000_0000;
        d[101:70] = 32'h7FFF_FFFF;
        d[142] = 0;
        send_tick(d);
        d[141:134] = 8'd0;
        d[142] = 1;
        send_tick(d);
        d[301:271] = '0;
        send_tick(d);
        d[141:134] = 8'd1;
        d[69:38] = 32'h7FFF_FFFF;
        d[133:102] = 32'h8000_0000;
        send_tick(d);
        for (int i = 0; i < 12; i++) send_tick(make_tick(6'($urandom_range(0, 3)), i % 3));

        // random phases under several rate settings
        for (int p = 0; p < 5; p++) begin
            write_rate(p < 4 ? rates[p] : 16'($urandom_range(1, 65535)));
            for (int i = 0; i < 260 && !timed_out; i++) begin
                if (p == 4 && i > 200) calm = 1;
                send_tick(make_tick(($urandom_range(0, 1)) ? 6'($urandom_range(0, 7))
                                   : 6'($urandom()), $urandom_range(0, 2)));
                if (i == 100) drain();
            end
        end
        drain();
        if (timed_out) $display("Regression FAIL");
        else begin
            $display("covered %0d joint ticks over five rate settings, both control modes",
                     ticks_sent);
            if (board.errors == 0 && board.pending_q.size() == 0)
                $display("Regression PASS");
            else $display("Regression FAIL");
        end
        $finish;
    end

    // end on a stalled block
    initial begin
        wait (timed_out);
        $display("Regression FAIL");
        $finish;
    end
endmodule
